/* hdl/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted
`define QSU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted
`define QSU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/qsu_pkg.sv */
package qsu_pkg;

    localparam int FRAC = 15;
    localparam int ONE_F = 1 << FRAC;
    localparam int WMAX_F = ONE_F * 4;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam int PI_F = int'((PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
    localparam int HALF_F = PI_F / 2;

    // sine: front stage, two stages per series term, final product
    localparam int SIN_STEPS = 8;
    localparam int SIN_LAT = 2 * SIN_STEPS + 2;

    // arcsine: one bit of the angle per search step
    localparam int ASIN_BITS = FRAC + 2;

    // distance: four arithmetic stages, then one square-root bit per stage
    localparam int SQ_STEPS = 16;
    localparam int DIST_LAT = 4 + SQ_STEPS;

    // weight quotient: range check stage, then one quotient bit per stage
    localparam int DIV_BITS = 18;
    localparam int DIV_LAT = DIV_BITS + 1;

    localparam int SMALL_SH = (FRAC + 1) / 2;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [16:0]      blend;
        logic             pass;
        logic             neg;
        logic [15:0]      s;
        logic [16:0]      phi;
        logic             small_ang;
        logic [15:0]      st;
    } ctx_t;

endpackage

/* hdl/quaternion_slerp_unit_core.sv */
// Quaternion slerp engine: takes a start and an end unit quaternion (Q1.15)
// plus a blend fraction (Q0.16, 65536 = 1.0) per word and returns the
// interpolated quaternion, rounded and saturated to Q1.15. A blend of 1.0 or
// more passes the end quaternion through; a negative dot product makes the
// unit interpolate toward the negated end. The core is fully pipelined: it
// takes one word every clock unless the pipeline holds. Most of its depth is
// the arcsine, a 17-step bit search in which every step runs a complete
// 18-stage sine series; the distance square root, the three sines of the
// weights and the two quotients make up the rest. A two-entry output buffer
// keeps s_tready independent of m_tready; while it is full the whole
// pipeline holds.
module quaternion_slerp_unit_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_w, start_x, start_y, start_z, end_w, end_x, end_y, end_z, blend
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_w, out_x, out_y, out_z
    output logic [63:0]  m_tdata
);
    import qsu_pkg::*;

    logic en;
    ctx_t in_ctx;

    logic dist_vld;
    ctx_t dist_ctx;
    logic asin_vld;
    ctx_t asin_ctx;

    logic        avld_reg;
    ctx_t        actx_reg;
    logic [16:0] theta_reg;
    logic [16:0] ang0_reg;
    logic [16:0] ang1_reg;

    logic [16:0] theta;
    logic [16:0] omb;
    logic [33:0] m0;
    logic [33:0] m1;
    ctx_t        actx_next;

    logic        st_vld;
    logic [15:0] st_sin;
    ctx_t        st_ctx;
    ctx_t        div_in_ctx;
    logic [15:0] sn0;
    logic [15:0] sn1;

    logic        dvld;
    logic [17:0] q0;
    logic [17:0] q1;
    ctx_t        dctx;

    logic        wvld_reg;
    ctx_t        wctx_reg;
    logic [17:0] w0_reg;
    logic [17:0] w1_reg;
    logic        use_trig;
    logic [16:0] lin_omb;

    logic               mvld_reg;
    logic               mpass_reg;
    logic               mneg_reg;
    logic [3:0][15:0]   mb_reg;
    logic signed [34:0] p0_reg [4];
    logic signed [34:0] p1_reg [4];

    logic [63:0] res;
    logic        take;
    logic        incoming;
    logic        out_vld_reg;
    logic [63:0] out_data_reg;
    logic        skid_vld_reg;
    logic [63:0] skid_data_reg;

    function automatic logic [15:0] round_sat(input logic signed [35:0] acc);
        logic [35:0] mag;
        logic [35:0] rnd;
        mag = acc[35] ? 36'(-acc) : 36'(acc);
        rnd = (mag + (36'd1 << (FRAC - 1))) >> FRAC;
        if (acc[35]) begin
            round_sat = (rnd > 36'd32768) ? 16'h8000 : 16'(~rnd + 36'd1);
        end else begin
            round_sat = (rnd > 36'd32767) ? 16'h7FFF : rnd[15:0];
        end
    endfunction

    // hold the whole pipeline while the spill register is occupied
    assign en = !skid_vld_reg;
    assign s_tready = en;

    always_comb begin
        in_ctx = '0;
        for (int i = 0; i < 4; i++) begin
            in_ctx.a[i] = s_tdata[16*i +: 16];
            in_ctx.b[i] = s_tdata[64 + 16*i +: 16];
        end
        in_ctx.blend = s_tdata[144:128];
        in_ctx.pass = s_tdata[144];
    end

    qsu_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_ctx    (in_ctx),
        .out_valid (dist_vld),
        .out_ctx   (dist_ctx)
    );

    qsu_asin u_asin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dist_vld),
        .in_ctx    (dist_ctx),
        .out_valid (asin_vld),
        .out_ctx   (asin_ctx)
    );

    // theta and the two partial angles
    always_comb begin
        theta = 17'({asin_ctx.phi, 1'b0});
        omb = 17'(17'h10000 - asin_ctx.blend);
        m0 = 34'(omb) * 34'(theta);
        m1 = 34'(asin_ctx.blend) * 34'(theta);
        actx_next = asin_ctx;
        actx_next.small_ang = ((theta >> SMALL_SH) == 17'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avld_reg <= 1'b0;
        end else if (en) begin
            avld_reg <= asin_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            actx_reg <= actx_next;
            theta_reg <= theta;
            ang0_reg <= m0[32:16];
            ang1_reg <= m1[32:16];
        end
    end

    qsu_sin u_sin_theta (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (avld_reg),
        .in_x      (theta_reg),
        .in_ctx    (actx_reg),
        .out_valid (st_vld),
        .out_sin   (st_sin),
        .out_ctx   (st_ctx)
    );

    qsu_sin u_sin_a0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (avld_reg),
        .in_x      (ang0_reg),
        .in_ctx    (actx_reg),
        .out_valid (),
        .out_sin   (sn0),
        .out_ctx   ()
    );

    qsu_sin u_sin_a1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (avld_reg),
        .in_x      (ang1_reg),
        .in_ctx    (actx_reg),
        .out_valid (),
        .out_sin   (sn1),
        .out_ctx   ()
    );

    always_comb begin
        div_in_ctx = st_ctx;
        div_in_ctx.st = st_sin;
    end

    qsu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_vld),
        .num0      (sn0),
        .num1      (sn1),
        .den       (st_sin),
        .in_ctx    (div_in_ctx),
        .out_valid (dvld),
        .out_q0    (q0),
        .out_q1    (q1),
        .out_ctx   (dctx)
    );

    // fall back to linear weights for a tiny angle or a zero sine
    always_comb begin
        use_trig = !dctx.small_ang && (dctx.st != 16'd0);
        lin_omb = 17'(17'h10000 - dctx.blend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvld_reg <= 1'b0;
            mvld_reg <= 1'b0;
        end else if (en) begin
            wvld_reg <= dvld;
            mvld_reg <= wvld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wctx_reg <= dctx;
            w0_reg <= use_trig ? q0 : 18'(lin_omb >> 1);
            w1_reg <= use_trig ? q1 : 18'(dctx.blend >> 1);
            mpass_reg <= wctx_reg.pass;
            mneg_reg <= wctx_reg.neg;
            mb_reg <= wctx_reg.b;
            for (int i = 0; i < 4; i++) begin
                p0_reg[i] <= $signed({1'b0, w0_reg}) * $signed(wctx_reg.a[i]);
                p1_reg[i] <= $signed({1'b0, w1_reg}) * $signed(wctx_reg.b[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (mpass_reg) begin
                res[16*i +: 16] = mb_reg[i];
            end else if (mneg_reg) begin
                res[16*i +: 16] = round_sat(36'(p0_reg[i]) - 36'(p1_reg[i]));
            end else begin
                res[16*i +: 16] = round_sat(36'(p0_reg[i]) + 36'(p1_reg[i]));
            end
        end
        take = out_vld_reg && m_tready;
        incoming = en && mvld_reg;
    end

    // output register with a spill slot behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || take) begin
            out_vld_reg <= skid_vld_reg || incoming;
            skid_vld_reg <= 1'b0;
        end else if (incoming) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || take) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : res;
        end else if (incoming) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/qsu_sin.sv */
module qsu_sin (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [16:0]   in_x,
    input  qsu_pkg::ctx_t in_ctx,
    output logic          out_valid,
    output logic [15:0]   out_sin,
    output qsu_pkg::ctx_t out_ctx
);
    import qsu_pkg::*;

    logic [SIN_LAT-1:0] vld_reg;
    ctx_t               ctx_reg [SIN_LAT];
    logic [15:0]        x_reg [SIN_LAT-1];
    logic [16:0]        x2_reg [2 * SIN_STEPS - 1];
    logic [16:0]        p_reg [SIN_STEPS];
    logic [15:0]        t_reg [SIN_STEPS];
    logic [15:0]        r_reg;

    logic [16:0] xc;
    logic [15:0] xr;
    logic [31:0] sq;
    logic [31:0] fin;
    logic [16:0] r_next;

    // clamp to pi and fold the upper half onto [0, pi/2]
    always_comb begin
        xc = (in_x > 17'(PI_F)) ? 17'(PI_F) : in_x;
        xr = (xc > 17'(HALF_F)) ? 16'(17'(PI_F) - xc) : xc[15:0];
        sq = 32'(xr) * 32'(xr);
        fin = 32'(x_reg[SIN_LAT-2]) * 32'(t_reg[SIN_STEPS-1]);
        r_next = fin[31:15];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SIN_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            for (int n = 1; n < SIN_LAT; n++) ctx_reg[n] <= ctx_reg[n-1];
            x_reg[0] <= xr;
            for (int n = 1; n < SIN_LAT - 1; n++) x_reg[n] <= x_reg[n-1];
            x2_reg[0] <= sq[31:15];
            for (int n = 1; n < 2 * SIN_STEPS - 1; n++) x2_reg[n] <= x2_reg[n-1];
            r_reg <= (r_next > 17'(ONE_F)) ? 16'(ONE_F) : r_next[15:0];
        end
    end

    // Horner series, highest term first: t = 1 - x^2*t / (k(k+1))
    for (genvar j = 0; j < SIN_STEPS; j++) begin : g_term
        localparam int unsigned K = 2 * (SIN_STEPS - j);
        localparam int unsigned D = K * (K + 1);
        localparam int unsigned L = $clog2(D);
        localparam int unsigned SH = 17 + L;
        localparam logic [63:0] M = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);

        logic [15:0] t_in;
        logic [32:0] prod;
        logic [34:0] recip;

        always_comb begin
            t_in = (j == 0) ? 16'(ONE_F) : t_reg[(j == 0) ? 0 : j - 1];
            prod = 33'(x2_reg[2*j]) * 33'(t_in);
            recip = 35'(p_reg[j]) * 35'(M);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[j] <= 17'(prod >> FRAC);
                t_reg[j] <= 16'(ONE_F) - 16'(recip >> SH);
            end
        end
    end

    assign out_valid = vld_reg[SIN_LAT-1];
    assign out_ctx   = ctx_reg[SIN_LAT-1];
    assign out_sin   = r_reg;

endmodule

/* hdl/qsu_dist.sv */
module qsu_dist (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  qsu_pkg::ctx_t in_ctx,
    output logic          out_valid,
    output qsu_pkg::ctx_t out_ctx
);
    import qsu_pkg::*;

    logic [DIST_LAT-1:0] vld_reg;
    ctx_t                ctx_reg [DIST_LAT];
    logic signed [31:0]  prod_reg [4];
    logic signed [16:0]  dsub_reg [4];
    logic signed [16:0]  dadd_reg [4];
    logic signed [17:0]  e_reg [4];
    logic [32:0]         sq_reg [4];
    logic [30:0]         v_reg;
    logic [17:0]         rem_reg [SQ_STEPS];
    logic [15:0]         root_reg [SQ_STEPS];
    logic [31:0]         vq_reg [SQ_STEPS];

    logic signed [33:0] dot;
    logic               neg_next;
    ctx_t               ctx1_next;
    logic [34:0]        ssum;
    logic [32:0]        sclamp;

    always_comb begin
        dot = '0;
        ssum = '0;
        for (int i = 0; i < 4; i++) begin
            dot = dot + 34'(prod_reg[i]);
            ssum = ssum + 35'(sq_reg[i]);
        end
        neg_next = dot[33];
        ctx1_next = ctx_reg[0];
        ctx1_next.neg = neg_next;
        sclamp = (ssum > (35'd1 << 32)) ? (33'd1 << 32) : ssum[32:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIST_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            ctx_reg[1] <= ctx1_next;
            for (int n = 2; n < DIST_LAT; n++) ctx_reg[n] <= ctx_reg[n-1];
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(in_ctx.a[i]) * $signed(in_ctx.b[i]);
                dsub_reg[i] <= 17'($signed(in_ctx.a[i])) - 17'($signed(in_ctx.b[i]));
                dadd_reg[i] <= 17'($signed(in_ctx.a[i])) + 17'($signed(in_ctx.b[i]));
                // against the negated end the difference becomes -(a + b)
                e_reg[i] <= neg_next ? -18'(dadd_reg[i]) : 18'(dsub_reg[i]);
                sq_reg[i] <= 33'(36'(e_reg[i]) * 36'(e_reg[i]));
            end
            v_reg <= sclamp[32:2];
        end
    end

    // floor square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [17:0] rem_in;
        logic [15:0] root_in;
        logic [31:0] v_in;
        logic [19:0] remx;
        logic [19:0] test;

        always_comb begin
            if (k == 0) begin
                rem_in = '0;
                root_in = '0;
                v_in = {1'b0, v_reg};
            end else begin
                rem_in = rem_reg[(k == 0) ? 0 : k - 1];
                root_in = root_reg[(k == 0) ? 0 : k - 1];
                v_in = vq_reg[(k == 0) ? 0 : k - 1];
            end
            remx = {rem_in, v_in[31:30]};
            test = {2'b00, root_in, 2'b01};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vq_reg[k] <= v_in << 2;
                if (remx >= test) begin
                    rem_reg[k] <= 18'(remx - test);
                    root_reg[k] <= {root_in[14:0], 1'b1};
                end else begin
                    rem_reg[k] <= remx[17:0];
                    root_reg[k] <= {root_in[14:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        out_ctx = ctx_reg[DIST_LAT-1];
        out_ctx.s = root_reg[SQ_STEPS-1];
    end

    assign out_valid = vld_reg[DIST_LAT-1];

endmodule

/* hdl/qsu_asin.sv */
module qsu_asin (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  qsu_pkg::ctx_t in_ctx,
    output logic          out_valid,
    output qsu_pkg::ctx_t out_ctx
);
    import qsu_pkg::*;

    ctx_t                 cin [ASIN_BITS];
    logic [ASIN_BITS-1:0] vin;
    ctx_t                 upd_reg [ASIN_BITS];
    logic [ASIN_BITS-1:0] vld_reg;

    // search the angle from the top bit down: keep a bit while sin stays <= s and the angle stays <= pi/2
    for (genvar i = 0; i < ASIN_BITS; i++) begin : g_bit
        localparam int B = ASIN_BITS - 1 - i;

        logic        sv;
        logic [15:0] ss;
        ctx_t        sc;
        logic [16:0] cand;
        ctx_t        upd_next;

        always_comb begin
            if (i == 0) begin
                cin[i] = in_ctx;
                cin[i].phi = '0;
                vin[i] = in_valid;
            end else begin
                cin[i] = upd_reg[(i == 0) ? 0 : i - 1];
                vin[i] = vld_reg[(i == 0) ? 0 : i - 1];
            end
        end

        qsu_sin u_sin (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (vin[i]),
            .in_x      (cin[i].phi | (17'd1 << B)),
            .in_ctx    (cin[i]),
            .out_valid (sv),
            .out_sin   (ss),
            .out_ctx   (sc)
        );

        always_comb begin
            cand = sc.phi | (17'd1 << B);
            upd_next = sc;
            if (cand <= 17'(HALF_F) && ss <= sc.s) begin
                upd_next.phi = cand;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= sv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                upd_reg[i] <= upd_next;
            end
        end
    end

    assign out_valid = vld_reg[ASIN_BITS-1];
    assign out_ctx   = upd_reg[ASIN_BITS-1];

endmodule

/* hdl/qsu_div.sv */
module qsu_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [15:0]   num0,
    input  logic [15:0]   num1,
    input  logic [15:0]   den,
    input  qsu_pkg::ctx_t in_ctx,
    output logic          out_valid,
    output logic [17:0]   out_q0,
    output logic [17:0]   out_q1,
    output qsu_pkg::ctx_t out_ctx
);
    import qsu_pkg::*;

    logic [DIV_LAT-1:0] vld_reg;
    ctx_t               ctx_reg [DIV_LAT];
    logic [15:0]        den_reg [DIV_LAT];
    logic [30:0]        rem_reg [DIV_LAT][2];
    logic [17:0]        q_reg [DIV_LAT][2];
    logic [1:0]         ovf_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_LAT-2:0], in_valid};
        end
    end

    // quotient of 2^18 or more saturates anyway: flag it up front
    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_reg[0] <= in_ctx;
            den_reg[0] <= den;
            rem_reg[0][0] <= {num0, 15'd0};
            rem_reg[0][1] <= {num1, 15'd0};
            q_reg[0][0] <= '0;
            q_reg[0][1] <= '0;
            ovf_reg[0] <= {19'(num1) >= {den, 3'b000}, 19'(num0) >= {den, 3'b000}};
            for (int n = 1; n < DIV_LAT; n++) begin
                ctx_reg[n] <= ctx_reg[n-1];
                den_reg[n] <= den_reg[n-1];
                ovf_reg[n] <= ovf_reg[n-1];
            end
        end
    end

    for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
        localparam int SH = DIV_BITS - 1 - i;

        logic [33:0] dsh;

        assign dsh = 34'(den_reg[i]) << SH;

        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (34'(rem_reg[i][l]) >= dsh) begin
                        rem_reg[i+1][l] <= 31'(34'(rem_reg[i][l]) - dsh);
                        q_reg[i+1][l] <= q_reg[i][l] | (18'd1 << SH);
                    end else begin
                        rem_reg[i+1][l] <= rem_reg[i][l];
                        q_reg[i+1][l] <= q_reg[i][l];
                    end
                end
            end
        end
    end

    always_comb begin
        out_q0 = (ovf_reg[DIV_LAT-1][0] || q_reg[DIV_LAT-1][0] > 18'(WMAX_F)) ?
                 18'(WMAX_F) : q_reg[DIV_LAT-1][0];
        out_q1 = (ovf_reg[DIV_LAT-1][1] || q_reg[DIV_LAT-1][1] > 18'(WMAX_F)) ?
                 18'(WMAX_F) : q_reg[DIV_LAT-1][1];
    end

    assign out_valid = vld_reg[DIV_LAT-1];
    assign out_ctx   = ctx_reg[DIV_LAT-1];

endmodule

/* hdl/qsu_checker.sv */
`include "assert_macros.svh"

module qsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    `QSU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
    `QSU_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result word changed")
    `QSU_ASSERT_IMP(a_reset_empty, $past(!aresetn), s_tready && !m_tvalid, "not empty after reset")
    `QSU_ASSERT_IMP(a_stall_full, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

bind quaternion_slerp_unit_core qsu_checker u_qsu_checker (.*);
